### rtl/core/g2h_pkg.sv
`timescale 1ns / 1ps
// Package for the Gregorian to Hijri table converter.
// Holds field widths, the control and status structs and the year ROM with its start dates.
// Depends on nothing.
package g2h_pkg;

    localparam int DAY_W     = 22;
    localparam int YEAR_W    = 11;
    localparam int MONTH_W   = 4;
    localparam int MDAY_W    = 5;
    localparam int YDAY_W    = 9;
    localparam int MASK_W    = 12;
    localparam int ROM_COUNT = 184;
    localparam int ROM_IDX_W = 8;

    // Day number of Gregorian 1900-01-01, counted from 0001-01-01.
    localparam int BASE_1900 = 693595;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [DAY_W-1:0]  start;
    } g2h_rec_t;

    typedef struct packed {
        logic load;
        logic search_step;
        logic walk_init;
        logic walk_step;
        logic out_load;
    } g2h_cmd_t;

    typedef struct packed {
        logic range_bad;
        logic search_done;
        logic walk_done;
    } g2h_status_t;

    function automatic int days_before_month(input int m);
        int r;
        case (m)
            2:       r = 31;
            3:       r = 59;
            4:       r = 90;
            5:       r = 120;
            6:       r = 151;
            7:       r = 181;
            8:       r = 212;
            9:       r = 243;
            10:      r = 273;
            11:      r = 304;
            12:      r = 334;
            default: r = 0;
        endcase
        return r;
    endfunction

    // Builds one ROM entry. The table only spans 1900..2077, so the century rule
    // reduces to 1900 being the one multiple of four that is not a leap year.
    function automatic g2h_rec_t mk(input int mask, input int y, input int m, input int d);
        int       k;
        int       leaps;
        int       days;
        g2h_rec_t r;
        k     = y - 1900;
        leaps = (k > 0) ? ((k - 1) >>> 2) : 0;
        days  = BASE_1900 + k * 365 + leaps + days_before_month(m) + d - 1;
        if (m > 2 && (k & 3) == 0 && k != 0)
        begin
            days = days + 1;
        end
        r.mask  = MASK_W'(mask);
        r.start = DAY_W'(days);
        return r;
    endfunction

    function automatic g2h_rec_t rom_rec(input logic [ROM_IDX_W-1:0] i);
        g2h_rec_t r;
        case (i)
            8'd0:    r = mk(12'h2EA, 1900,  4, 30);
            8'd1:    r = mk(12'h6E9, 1901,  4, 19);
            8'd2:    r = mk(12'hED2, 1902,  4,  9);
            8'd3:    r = mk(12'hEA4, 1903,  3, 30);
            8'd4:    r = mk(12'hD4A, 1904,  3, 18);
            8'd5:    r = mk(12'hA96, 1905,  3,  7);
            8'd6:    r = mk(12'h536, 1906,  2, 24);
            8'd7:    r = mk(12'hAB5, 1907,  2, 13);
            8'd8:    r = mk(12'hDAA, 1908,  2,  3);
            8'd9:    r = mk(12'hBA4, 1909,  1, 23);
            8'd10:   r = mk(12'hB49, 1910,  1, 12);
            8'd11:   r = mk(12'hA93, 1911,  1,  1);
            8'd12:   r = mk(12'h52B, 1911, 12, 21);
            8'd13:   r = mk(12'hA57, 1912, 12,  9);
            8'd14:   r = mk(12'h4B6, 1913, 11, 29);
            8'd15:   r = mk(12'hAB5, 1914, 11, 18);
            8'd16:   r = mk(12'h5AA, 1915, 11,  8);
            8'd17:   r = mk(12'hD55, 1916, 10, 27);
            8'd18:   r = mk(12'hD2A, 1917, 10, 17);
            8'd19:   r = mk(12'hA56, 1918, 10,  6);
            8'd20:   r = mk(12'h4AE, 1919,  9, 25);
            8'd21:   r = mk(12'h95D, 1920,  9, 13);
            8'd22:   r = mk(12'h2EC, 1921,  9,  3);
            8'd23:   r = mk(12'h6D5, 1922,  8, 23);
            8'd24:   r = mk(12'h6AA, 1923,  8, 13);
            8'd25:   r = mk(12'h555, 1924,  8,  1);
            8'd26:   r = mk(12'h4AB, 1925,  7, 21);
            8'd27:   r = mk(12'h95B, 1926,  7, 10);
            8'd28:   r = mk(12'h2BA, 1927,  6, 30);
            8'd29:   r = mk(12'h575, 1928,  6, 18);
            8'd30:   r = mk(12'hBB2, 1929,  6,  8);
            8'd31:   r = mk(12'h764, 1930,  5, 29);
            8'd32:   r = mk(12'h749, 1931,  5, 18);
            8'd33:   r = mk(12'h655, 1932,  5,  6);
            8'd34:   r = mk(12'h2AB, 1933,  4, 25);
            8'd35:   r = mk(12'h55B, 1934,  4, 14);
            8'd36:   r = mk(12'hADA, 1935,  4,  4);
            8'd37:   r = mk(12'h6D4, 1936,  3, 24);
            8'd38:   r = mk(12'hEC9, 1937,  3, 13);
            8'd39:   r = mk(12'hD92, 1938,  3,  3);
            8'd40:   r = mk(12'hD25, 1939,  2, 20);
            8'd41:   r = mk(12'hA4D, 1940,  2,  9);
            8'd42:   r = mk(12'h2AD, 1941,  1, 28);
            8'd43:   r = mk(12'h56D, 1942,  1, 17);
            8'd44:   r = mk(12'hB6A, 1943,  1,  7);
            8'd45:   r = mk(12'hB52, 1943, 12, 28);
            8'd46:   r = mk(12'hAA5, 1944, 12, 16);
            8'd47:   r = mk(12'hA4B, 1945, 12,  5);
            8'd48:   r = mk(12'h497, 1946, 11, 24);
            8'd49:   r = mk(12'h937, 1947, 11, 13);
            8'd50:   r = mk(12'h2B6, 1948, 11,  2);
            8'd51:   r = mk(12'h575, 1949, 10, 22);
            8'd52:   r = mk(12'hD6A, 1950, 10, 12);
            8'd53:   r = mk(12'hD52, 1951, 10,  2);
            8'd54:   r = mk(12'hA96, 1952,  9, 20);
            8'd55:   r = mk(12'h92D, 1953,  9,  9);
            8'd56:   r = mk(12'h25D, 1954,  8, 29);
            8'd57:   r = mk(12'h4DD, 1955,  8, 18);
            8'd58:   r = mk(12'hADA, 1956,  8,  7);
            8'd59:   r = mk(12'h5D4, 1957,  7, 28);
            8'd60:   r = mk(12'hDA9, 1958,  7, 17);
            8'd61:   r = mk(12'hD52, 1959,  7,  7);
            8'd62:   r = mk(12'hAAA, 1960,  6, 25);
            8'd63:   r = mk(12'h4D6, 1961,  6, 14);
            8'd64:   r = mk(12'h9B6, 1962,  6,  3);
            8'd65:   r = mk(12'h374, 1963,  5, 24);
            8'd66:   r = mk(12'h769, 1964,  5, 12);
            8'd67:   r = mk(12'h752, 1965,  5,  2);
            8'd68:   r = mk(12'h6A5, 1966,  4, 21);
            8'd69:   r = mk(12'h54B, 1967,  4, 10);
            8'd70:   r = mk(12'hAAB, 1968,  3, 29);
            8'd71:   r = mk(12'h55A, 1969,  3, 19);
            8'd72:   r = mk(12'hAD5, 1970,  3,  8);
            8'd73:   r = mk(12'hDD2, 1971,  2, 26);
            8'd74:   r = mk(12'hDA4, 1972,  2, 16);
            8'd75:   r = mk(12'hD49, 1973,  2,  4);
            8'd76:   r = mk(12'hA95, 1974,  1, 24);
            8'd77:   r = mk(12'h52D, 1975,  1, 13);
            8'd78:   r = mk(12'hA5D, 1976,  1,  2);
            8'd79:   r = mk(12'h55A, 1976, 12, 22);
            8'd80:   r = mk(12'hAD5, 1977, 12, 11);
            8'd81:   r = mk(12'h6AA, 1978, 12,  1);
            8'd82:   r = mk(12'h695, 1979, 11, 20);
            8'd83:   r = mk(12'h52B, 1980, 11,  8);
            8'd84:   r = mk(12'hA57, 1981, 10, 28);
            8'd85:   r = mk(12'h4AE, 1982, 10, 18);
            8'd86:   r = mk(12'h976, 1983, 10,  7);
            8'd87:   r = mk(12'h56C, 1984,  9, 26);
            8'd88:   r = mk(12'hB55, 1985,  9, 15);
            8'd89:   r = mk(12'hAAA, 1986,  9,  5);
            8'd90:   r = mk(12'hA55, 1987,  8, 25);
            8'd91:   r = mk(12'h4AD, 1988,  8, 13);
            8'd92:   r = mk(12'h95D, 1989,  8,  2);
            8'd93:   r = mk(12'h2DA, 1990,  7, 23);
            8'd94:   r = mk(12'h5D9, 1991,  7, 12);
            8'd95:   r = mk(12'hDB2, 1992,  7,  1);
            8'd96:   r = mk(12'hBA4, 1993,  6, 21);
            8'd97:   r = mk(12'hB4A, 1994,  6, 10);
            8'd98:   r = mk(12'hA55, 1995,  5, 30);
            8'd99:   r = mk(12'h2B5, 1996,  5, 18);
            8'd100:  r = mk(12'h575, 1997,  5,  7);
            8'd101:  r = mk(12'hB6A, 1998,  4, 27);
            8'd102:  r = mk(12'hBD2, 1999,  4, 17);
            8'd103:  r = mk(12'hBC4, 2000,  4,  6);
            8'd104:  r = mk(12'hB89, 2001,  3, 26);
            8'd105:  r = mk(12'hA95, 2002,  3, 15);
            8'd106:  r = mk(12'h52D, 2003,  3,  4);
            8'd107:  r = mk(12'h5AD, 2004,  2, 21);
            8'd108:  r = mk(12'hB6A, 2005,  2, 10);
            8'd109:  r = mk(12'h6D4, 2006,  1, 31);
            8'd110:  r = mk(12'hDC9, 2007,  1, 20);
            8'd111:  r = mk(12'hD92, 2008,  1, 10);
            8'd112:  r = mk(12'hAA6, 2008, 12, 29);
            8'd113:  r = mk(12'h956, 2009, 12, 18);
            8'd114:  r = mk(12'h2AE, 2010, 12,  7);
            8'd115:  r = mk(12'h56D, 2011, 11, 26);
            8'd116:  r = mk(12'h36A, 2012, 11, 15);
            8'd117:  r = mk(12'hB55, 2013, 11,  4);
            8'd118:  r = mk(12'hAAA, 2014, 10, 25);
            8'd119:  r = mk(12'h94D, 2015, 10, 14);
            8'd120:  r = mk(12'h49D, 2016, 10,  2);
            8'd121:  r = mk(12'h95D, 2017,  9, 21);
            8'd122:  r = mk(12'h2BA, 2018,  9, 11);
            8'd123:  r = mk(12'h5B5, 2019,  8, 31);
            8'd124:  r = mk(12'h5AA, 2020,  8, 20);
            8'd125:  r = mk(12'hD55, 2021,  8,  9);
            8'd126:  r = mk(12'hA9A, 2022,  7, 30);
            8'd127:  r = mk(12'h92E, 2023,  7, 19);
            8'd128:  r = mk(12'h26E, 2024,  7,  7);
            8'd129:  r = mk(12'h55D, 2025,  6, 26);
            8'd130:  r = mk(12'hADA, 2026,  6, 16);
            8'd131:  r = mk(12'h6D4, 2027,  6,  6);
            8'd132:  r = mk(12'h6A5, 2028,  5, 25);
            8'd133:  r = mk(12'h54B, 2029,  5, 14);
            8'd134:  r = mk(12'hA97, 2030,  5,  3);
            8'd135:  r = mk(12'h54E, 2031,  4, 23);
            8'd136:  r = mk(12'hAAE, 2032,  4, 11);
            8'd137:  r = mk(12'h5AC, 2033,  4,  1);
            8'd138:  r = mk(12'hBA9, 2034,  3, 21);
            8'd139:  r = mk(12'hD92, 2035,  3, 11);
            8'd140:  r = mk(12'hB25, 2036,  2, 28);
            8'd141:  r = mk(12'h64B, 2037,  2, 16);
            8'd142:  r = mk(12'hCAB, 2038,  2,  5);
            8'd143:  r = mk(12'h55A, 2039,  1, 26);
            8'd144:  r = mk(12'hB55, 2040,  1, 15);
            8'd145:  r = mk(12'h6D2, 2041,  1,  4);
            8'd146:  r = mk(12'hEA5, 2041, 12, 24);
            8'd147:  r = mk(12'hE4A, 2042, 12, 14);
            8'd148:  r = mk(12'hA95, 2043, 12,  3);
            8'd149:  r = mk(12'h52D, 2044, 11, 21);
            8'd150:  r = mk(12'hAAD, 2045, 11, 10);
            8'd151:  r = mk(12'h36C, 2046, 10, 31);
            8'd152:  r = mk(12'h759, 2047, 10, 20);
            8'd153:  r = mk(12'h6D2, 2048, 10,  9);
            8'd154:  r = mk(12'h695, 2049,  9, 28);
            8'd155:  r = mk(12'h52D, 2050,  9, 17);
            8'd156:  r = mk(12'hA5B, 2051,  9,  6);
            8'd157:  r = mk(12'h4BA, 2052,  8, 26);
            8'd158:  r = mk(12'h9BA, 2053,  8, 15);
            8'd159:  r = mk(12'h3B4, 2054,  8,  5);
            8'd160:  r = mk(12'hB69, 2055,  7, 25);
            8'd161:  r = mk(12'hB52, 2056,  7, 14);
            8'd162:  r = mk(12'hAA6, 2057,  7,  3);
            8'd163:  r = mk(12'h4B6, 2058,  6, 22);
            8'd164:  r = mk(12'h96D, 2059,  6, 11);
            8'd165:  r = mk(12'h2EC, 2060,  5, 31);
            8'd166:  r = mk(12'h6D9, 2061,  5, 20);
            8'd167:  r = mk(12'hEB2, 2062,  5, 10);
            8'd168:  r = mk(12'hD54, 2063,  4, 30);
            8'd169:  r = mk(12'hD2A, 2064,  4, 18);
            8'd170:  r = mk(12'hA56, 2065,  4,  7);
            8'd171:  r = mk(12'h4AE, 2066,  3, 27);
            8'd172:  r = mk(12'h96D, 2067,  3, 16);
            8'd173:  r = mk(12'hD6A, 2068,  3,  5);
            8'd174:  r = mk(12'hB54, 2069,  2, 23);
            8'd175:  r = mk(12'hB29, 2070,  2, 12);
            8'd176:  r = mk(12'hA93, 2071,  2,  1);
            8'd177:  r = mk(12'h52B, 2072,  1, 21);
            8'd178:  r = mk(12'hA57, 2073,  1,  9);
            8'd179:  r = mk(12'h536, 2073, 12, 30);
            8'd180:  r = mk(12'hAB5, 2074, 12, 19);
            8'd181:  r = mk(12'h6AA, 2075, 12,  9);
            8'd182:  r = mk(12'hE93, 2076, 11, 27);
            8'd183:  r = mk(12'h000, 2077, 11, 17);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/g2h_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the Gregorian to Hijri table converter.
// Depends on g2h_pkg for the field widths.
interface g2h_day_if;
    logic                        valid;
    logic                        ready;
    logic [g2h_pkg::DAY_W-1:0]   day_number;

    modport source (output valid, output day_number, input ready);
    modport sink (input valid, input day_number, output ready);
endinterface

interface g2h_hijri_if;
    logic                        valid;
    logic                        ready;
    logic [g2h_pkg::YEAR_W-1:0]  hijri_year;
    logic [g2h_pkg::MONTH_W-1:0] hijri_month;
    logic [g2h_pkg::MDAY_W-1:0]  hijri_day;
    logic [g2h_pkg::YDAY_W-1:0]  year_day;
    logic                        out_of_range;

    modport source (output valid, output hijri_year, output hijri_month, output hijri_day,
                    output year_day, output out_of_range, input ready);
    modport sink (input valid, input hijri_year, input hijri_month, input hijri_day,
                  input year_day, input out_of_range, output ready);
endinterface

### rtl/core/g2h_ctrl.sv
`timescale 1ns / 1ps
// Controller of the Gregorian to Hijri table converter: sequences the range check,
// year search and month walk, and owns the output valid flag. Depends on g2h_pkg.
module g2h_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  g2h_pkg::g2h_status_t status,
    output g2h_pkg::g2h_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.range_bad ? ST_OUT : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_OUT:
            begin
                // The result register may still hold the previous transaction.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/g2h_datapath.sv
`timescale 1ns / 1ps
// Datapath of the Gregorian to Hijri table converter: binary search over the year ROM,
// month walk and the result register. Depends on g2h_pkg.
module g2h_datapath #(
    parameter int ENTRIES    = 184,
    parameter int FIRST_YEAR = 1318
) (
    input  logic                          clk,
    input  g2h_pkg::g2h_cmd_t             cmd,
    input  logic [g2h_pkg::DAY_W-1:0]     day_number,
    output g2h_pkg::g2h_status_t          status,
    output logic [g2h_pkg::YEAR_W-1:0]    hijri_year,
    output logic [g2h_pkg::MONTH_W-1:0]   hijri_month,
    output logic [g2h_pkg::MDAY_W-1:0]    hijri_day,
    output logic [g2h_pkg::YDAY_W-1:0]    year_day,
    output logic                          out_of_range
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam g2h_pkg::g2h_rec_t FIRST_REC = g2h_pkg::rom_rec(8'd0);
    localparam g2h_pkg::g2h_rec_t LAST_REC  =
        g2h_pkg::rom_rec(g2h_pkg::ROM_IDX_W'(ENTRIES - 1));

    logic [g2h_pkg::DAY_W-1:0]   day_reg;
    logic [IDX_W-1:0]            lo_reg;
    logic [IDX_W-1:0]            hi_reg;
    logic [g2h_pkg::YDAY_W-1:0]  rem_reg;
    logic [g2h_pkg::YDAY_W-1:0]  yday_reg;
    logic [g2h_pkg::MASK_W-1:0]  mask_reg;
    logic [g2h_pkg::MONTH_W-1:0] month_reg;

    logic [g2h_pkg::YEAR_W-1:0]  year_out_reg;
    logic [g2h_pkg::MONTH_W-1:0] month_out_reg;
    logic [g2h_pkg::MDAY_W-1:0]  mday_out_reg;
    logic [g2h_pkg::YDAY_W-1:0]  yday_out_reg;
    logic                        oor_out_reg;

    logic [IDX_W:0]              idx_sum;
    logic [IDX_W-1:0]            mid;
    logic [IDX_W:0]              lo_inc;
    g2h_pkg::g2h_rec_t           mid_rec;
    g2h_pkg::g2h_rec_t           lo_rec;
    logic [g2h_pkg::DAY_W-1:0]   diff;
    logic [g2h_pkg::MDAY_W-1:0]  month_len;

    assign idx_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = idx_sum[IDX_W:1];
    assign lo_inc    = {1'b0, lo_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign mid_rec   = g2h_pkg::rom_rec(g2h_pkg::ROM_IDX_W'(mid));
    assign lo_rec    = g2h_pkg::rom_rec(g2h_pkg::ROM_IDX_W'(lo_reg));
    assign diff      = day_reg - lo_rec.start;
    assign month_len = 5'd29 + {4'b0000, mask_reg[0]};

    // The search keeps start(lo) <= day < start(hi) until hi is one above lo.
    assign status.range_bad   = (day_reg < FIRST_REC.start) || (day_reg >= LAST_REC.start);
    assign status.search_done = ({1'b0, hi_reg} == lo_inc);
    assign status.walk_done   = (rem_reg < {4'b0000, month_len}) || (month_reg == 4'd12);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            day_reg <= day_number;
            lo_reg  <= '0;
            hi_reg  <= IDX_W'(ENTRIES - 1);
        end
        if (cmd.search_step)
        begin
            if (mid_rec.start <= day_reg)
            begin
                lo_reg <= mid;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.walk_init)
        begin
            rem_reg   <= diff[g2h_pkg::YDAY_W-1:0];
            yday_reg  <= diff[g2h_pkg::YDAY_W-1:0] + 9'd1;
            mask_reg  <= lo_rec.mask;
            month_reg <= 4'd1;
        end
        if (cmd.walk_step)
        begin
            rem_reg   <= rem_reg - {4'b0000, month_len};
            mask_reg  <= {1'b0, mask_reg[g2h_pkg::MASK_W-1:1]};
            month_reg <= month_reg + 4'd1;
        end
        if (cmd.out_load)
        begin
            if (status.range_bad)
            begin
                year_out_reg  <= '0;
                month_out_reg <= '0;
                mday_out_reg  <= '0;
                yday_out_reg  <= '0;
                oor_out_reg   <= 1'b1;
            end
            else
            begin
                year_out_reg  <= g2h_pkg::YEAR_W'(FIRST_YEAR) + g2h_pkg::YEAR_W'(lo_reg);
                month_out_reg <= month_reg;
                mday_out_reg  <= rem_reg[g2h_pkg::MDAY_W-1:0] + 5'd1;
                yday_out_reg  <= yday_reg;
                oor_out_reg   <= 1'b0;
            end
        end
    end

    assign hijri_year   = year_out_reg;
    assign hijri_month  = month_out_reg;
    assign hijri_day    = mday_out_reg;
    assign year_day     = yday_out_reg;
    assign out_of_range = oor_out_reg;

endmodule

### rtl/core/gregorian_to_hijri_table.sv
`timescale 1ns / 1ps
// Top level of the Gregorian to Hijri table converter.
// Depends on g2h_pkg, g2h_ifs, g2h_ctrl and g2h_datapath.
//
// Usage: the gregorian channel takes one day number (days since 0001-01-01) per
// transaction; the hijri channel returns one transaction per input with year, month,
// day of month, day of year and an out-of-range flag (all other fields zero then).
// Items are handled one at a time: ready on the gregorian channel is high only while
// the controller waits for a new item.
// From acceptance, the controller checks the range; a date outside the table goes
// straight to the result, otherwise it runs the binary search over the year ROM
// (up to ceil(log2(YEAR_ENTRIES - 1)) steps, 7 or 8 for the full table) and then the
// month walk, one step per month passed (0..11), before the result is loaded.
// After the result is loaded the controller returns to idle and accepts the next item.
// The result sits in an output register, so a new item is accepted while the previous
// result waits; if the receiver still stalls when the next result is ready, the
// controller holds it until the output register frees up.
// Reset clears the controller and the output valid flag; the datapath registers have no reset.
module gregorian_to_hijri_table #(
    parameter int YEAR_ENTRIES = 184,
    parameter int FIRST_YEAR   = 1318
) (
    input  logic           clk,
    input  logic           rst_n,
    g2h_day_if.sink        gregorian,
    g2h_hijri_if.source    hijri
);

    localparam int COUNT = (YEAR_ENTRIES < g2h_pkg::ROM_COUNT) ? YEAR_ENTRIES
                                                               : g2h_pkg::ROM_COUNT;

    g2h_pkg::g2h_cmd_t    cmd;
    g2h_pkg::g2h_status_t status;

    g2h_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gregorian.valid),
        .in_ready  (gregorian.ready),
        .out_valid (hijri.valid),
        .out_ready (hijri.ready),
        .status    (status),
        .cmd       (cmd)
    );

    g2h_datapath #(
        .ENTRIES    (COUNT),
        .FIRST_YEAR (FIRST_YEAR)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .day_number   (gregorian.day_number),
        .status       (status),
        .hijri_year   (hijri.hijri_year),
        .hijri_month  (hijri.hijri_month),
        .hijri_day    (hijri.hijri_day),
        .year_day     (hijri.year_day),
        .out_of_range (hijri.out_of_range)
    );

    // One item at a time: after an accepted transaction the input stays closed.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (gregorian.valid && gregorian.ready) |=> !gregorian.ready)
        else $error("input accepted while an item is in flight");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hijri.valid && hijri.out_of_range) |->
        (hijri.hijri_year == 0 && hijri.hijri_month == 0 &&
         hijri.hijri_day == 0 && hijri.year_day == 0))
        else $error("out-of-range result with nonzero fields");

    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (hijri.valid && !hijri.out_of_range) |->
        (hijri.hijri_month >= 1 && hijri.hijri_month <= 12 &&
         hijri.hijri_day >= 1 && hijri.hijri_day <= 30 &&
         hijri.year_day >= 1 && hijri.year_day <= 355))
        else $error("in-range result with an impossible date");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!hijri.valid || hijri.ready))
        else $error("result register overwritten before it was taken");

endmodule

### sim/gregorian_to_hijri_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_to_hijri_table: a short table of directed day numbers,
// then random ones, each result checked against a probe's own date or an in-bench Umm al-Qura year lookup.
// Depends on g2h_pkg, the g2h_ifs channel interfaces and the converter RTL.
module gregorian_to_hijri_table_tb;

    localparam int YEAR_ENTRIES   = 184;
    localparam int FIRST_YEAR     = 1318;
    localparam int ROM_ROWS       = 184;
    localparam int USED_ROWS      = (YEAR_ENTRIES < ROM_ROWS) ? YEAR_ENTRIES : ROM_ROWS;
    localparam int DAY_MAX        = 3652058;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int QUIET_TAIL     = 150;
    localparam int CHOKE_AT       = 400;
    localparam int CHOKE_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_PROBES     = 16;
    localparam int NO_ANCHOR      = -1;

    typedef struct packed {
        logic [g2h_pkg::YEAR_W-1:0]  hijri_year;
        logic [g2h_pkg::MONTH_W-1:0] hijri_month;
        logic [g2h_pkg::MDAY_W-1:0]  hijri_day;
        logic [g2h_pkg::YDAY_W-1:0]  year_day;
        logic                        out_of_range;
    } hijri_date_t;

    // A probe is either an absolute day number (anchor NO_ANCHOR) or an offset from
    // the first day of a table year. Typed probes carry their own expected date.
    typedef struct packed {
        int          anchor;
        int          offset;
        logic        typed;
        hijri_date_t want;
    } probe_t;

    localparam hijri_date_t NO_DATE = '0;
    localparam hijri_date_t OUTSIDE_DATE = '{hijri_year: 0, hijri_month: 0, hijri_day: 0,
                                             year_day: 0, out_of_range: 1'b1};
    localparam hijri_date_t FIRST_DATE = '{hijri_year: 11'd1318, hijri_month: 4'd1,
                                           hijri_day: 5'd1, year_day: 9'd1, out_of_range: 1'b0};

    logic clk;
    logic rst_n;

    g2h_day_if   gregorian();
    g2h_hijri_if hijri();

    gregorian_to_hijri_table #(
        .YEAR_ENTRIES (YEAR_ENTRIES),
        .FIRST_YEAR   (FIRST_YEAR)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .gregorian (gregorian),
        .hijri     (hijri)
    );

    // Per Hijri year: 30-day month mask, then Gregorian year, month and day of its first day.
    int year_rows [0:4*ROM_ROWS-1] = '{
        'h2EA,1900,4,30,   'h6E9,1901,4,19,   'hED2,1902,4,9,    'hEA4,1903,3,30,
        'hD4A,1904,3,18,   'hA96,1905,3,7,    'h536,1906,2,24,   'hAB5,1907,2,13,
        'hDAA,1908,2,3,    'hBA4,1909,1,23,   'hB49,1910,1,12,   'hA93,1911,1,1,
        'h52B,1911,12,21,  'hA57,1912,12,9,   'h4B6,1913,11,29,  'hAB5,1914,11,18,
        'h5AA,1915,11,8,   'hD55,1916,10,27,  'hD2A,1917,10,17,  'hA56,1918,10,6,
        'h4AE,1919,9,25,   'h95D,1920,9,13,   'h2EC,1921,9,3,    'h6D5,1922,8,23,
        'h6AA,1923,8,13,   'h555,1924,8,1,    'h4AB,1925,7,21,   'h95B,1926,7,10,
        'h2BA,1927,6,30,   'h575,1928,6,18,   'hBB2,1929,6,8,    'h764,1930,5,29,
        'h749,1931,5,18,   'h655,1932,5,6,    'h2AB,1933,4,25,   'h55B,1934,4,14,
        'hADA,1935,4,4,    'h6D4,1936,3,24,   'hEC9,1937,3,13,   'hD92,1938,3,3,
        'hD25,1939,2,20,   'hA4D,1940,2,9,    'h2AD,1941,1,28,   'h56D,1942,1,17,
        'hB6A,1943,1,7,    'hB52,1943,12,28,  'hAA5,1944,12,16,  'hA4B,1945,12,5,
        'h497,1946,11,24,  'h937,1947,11,13,  'h2B6,1948,11,2,   'h575,1949,10,22,
        'hD6A,1950,10,12,  'hD52,1951,10,2,   'hA96,1952,9,20,   'h92D,1953,9,9,
        'h25D,1954,8,29,   'h4DD,1955,8,18,   'hADA,1956,8,7,    'h5D4,1957,7,28,
        'hDA9,1958,7,17,   'hD52,1959,7,7,    'hAAA,1960,6,25,   'h4D6,1961,6,14,
        'h9B6,1962,6,3,    'h374,1963,5,24,   'h769,1964,5,12,   'h752,1965,5,2,
        'h6A5,1966,4,21,   'h54B,1967,4,10,   'hAAB,1968,3,29,   'h55A,1969,3,19,
        'hAD5,1970,3,8,    'hDD2,1971,2,26,   'hDA4,1972,2,16,   'hD49,1973,2,4,
        'hA95,1974,1,24,   'h52D,1975,1,13,   'hA5D,1976,1,2,    'h55A,1976,12,22,
        'hAD5,1977,12,11,  'h6AA,1978,12,1,   'h695,1979,11,20,  'h52B,1980,11,8,
        'hA57,1981,10,28,  'h4AE,1982,10,18,  'h976,1983,10,7,   'h56C,1984,9,26,
        'hB55,1985,9,15,   'hAAA,1986,9,5,    'hA55,1987,8,25,   'h4AD,1988,8,13,
        'h95D,1989,8,2,    'h2DA,1990,7,23,   'h5D9,1991,7,12,   'hDB2,1992,7,1,
        'hBA4,1993,6,21,   'hB4A,1994,6,10,   'hA55,1995,5,30,   'h2B5,1996,5,18,
        'h575,1997,5,7,    'hB6A,1998,4,27,   'hBD2,1999,4,17,   'hBC4,2000,4,6,
        'hB89,2001,3,26,   'hA95,2002,3,15,   'h52D,2003,3,4,    'h5AD,2004,2,21,
        'hB6A,2005,2,10,   'h6D4,2006,1,31,   'hDC9,2007,1,20,   'hD92,2008,1,10,
        'hAA6,2008,12,29,  'h956,2009,12,18,  'h2AE,2010,12,7,   'h56D,2011,11,26,
        'h36A,2012,11,15,  'hB55,2013,11,4,   'hAAA,2014,10,25,  'h94D,2015,10,14,
        'h49D,2016,10,2,   'h95D,2017,9,21,   'h2BA,2018,9,11,   'h5B5,2019,8,31,
        'h5AA,2020,8,20,   'hD55,2021,8,9,    'hA9A,2022,7,30,   'h92E,2023,7,19,
        'h26E,2024,7,7,    'h55D,2025,6,26,   'hADA,2026,6,16,   'h6D4,2027,6,6,
        'h6A5,2028,5,25,   'h54B,2029,5,14,   'hA97,2030,5,3,    'h54E,2031,4,23,
        'hAAE,2032,4,11,   'h5AC,2033,4,1,    'hBA9,2034,3,21,   'hD92,2035,3,11,
        'hB25,2036,2,28,   'h64B,2037,2,16,   'hCAB,2038,2,5,    'h55A,2039,1,26,
        'hB55,2040,1,15,   'h6D2,2041,1,4,    'hEA5,2041,12,24,  'hE4A,2042,12,14,
        'hA95,2043,12,3,   'h52D,2044,11,21,  'hAAD,2045,11,10,  'h36C,2046,10,31,
        'h759,2047,10,20,  'h6D2,2048,10,9,   'h695,2049,9,28,   'h52D,2050,9,17,
        'hA5B,2051,9,6,    'h4BA,2052,8,26,   'h9BA,2053,8,15,   'h3B4,2054,8,5,
        'hB69,2055,7,25,   'hB52,2056,7,14,   'hAA6,2057,7,3,    'h4B6,2058,6,22,
        'h96D,2059,6,11,   'h2EC,2060,5,31,   'h6D9,2061,5,20,   'hEB2,2062,5,10,
        'hD54,2063,4,30,   'hD2A,2064,4,18,   'hA56,2065,4,7,    'h4AE,2066,3,27,
        'h96D,2067,3,16,   'hD6A,2068,3,5,    'hB54,2069,2,23,   'hB29,2070,2,12,
        'hA93,2071,2,1,    'h52B,2072,1,21,   'hA57,2073,1,9,    'h536,2073,12,30,
        'hAB5,2074,12,19,  'h6AA,2075,12,9,   'hE93,2076,11,27,  'h000,2077,11,17
    };

    probe_t probes [0:NUM_PROBES-1] = '{
        '{NO_ANCHOR, 0,       1'b1, OUTSIDE_DATE},
        '{NO_ANCHOR, DAY_MAX, 1'b1, OUTSIDE_DATE},
        '{NO_ANCHOR, 693713,  1'b1, OUTSIDE_DATE},
        '{NO_ANCHOR, 693714,  1'b1, FIRST_DATE},
        '{NO_ANCHOR, 758564,  1'b1, OUTSIDE_DATE},
        '{NO_ANCHOR, 2097151, 1'b1, OUTSIDE_DATE},
        '{NO_ANCHOR, 2097152, 1'b1, OUTSIDE_DATE},
        '{0,   29,  1'b0, NO_DATE},
        '{1,   -1,  1'b0, NO_DATE},
        '{1,   0,   1'b0, NO_DATE},
        '{2,   -1,  1'b0, NO_DATE},
        '{100, 200, 1'b0, NO_DATE},
        '{50,  353, 1'b0, NO_DATE},
        '{182, 0,   1'b0, NO_DATE},
        '{183, -1,  1'b0, NO_DATE},
        '{120, 150, 1'b0, NO_DATE}
    };

    int unsigned  year_start [0:ROM_ROWS-1];
    hijri_date_t  expected_dates [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    bit           idle_on = 1'b1;
    bit           choke_req = 1'b0;

    always #1 clk = ~clk;

    // Zero-based day count from 0001-01-01 under the proleptic Gregorian rules.
    function automatic int unsigned gregorian_day(input int y, input int m, input int d);
        int  p;
        int  days;
        p    = y - 1;
        days = p * 365 + p / 4 - p / 100 + p / 400;
        case (m)
            2:       days += 31;
            3:       days += 59;
            4:       days += 90;
            5:       days += 120;
            6:       days += 151;
            7:       days += 181;
            8:       days += 212;
            9:       days += 243;
            10:      days += 273;
            11:      days += 304;
            12:      days += 334;
            default: days += 0;
        endcase
        if (m > 2 && (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0))
        begin
            days += 1;
        end
        return days + d - 1;
    endfunction

    function automatic hijri_date_t convert_day(input logic [g2h_pkg::DAY_W-1:0] day);
        hijri_date_t  r;
        int unsigned  d;
        int unsigned  rem;
        int unsigned  len;
        int unsigned  month;
        int           idx;
        int           i;
        int           last;
        logic [11:0]  mask;
        r    = '0;
        d    = day;
        last = USED_ROWS - 1;
        if (d < year_start[0] || d >= year_start[last])
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        // Year starts rise monotonically, so the last start on or before the day wins.
        idx = 0;
        for (i = 1; i < last; i++)
        begin
            if (year_start[i] <= d)
            begin
                idx = i;
            end
        end
        rem   = d - year_start[idx];
        mask  = year_rows[4*idx];
        month = 1;
        len   = 29 + mask[0];
        while (rem >= len && month < 12)
        begin
            rem   -= len;
            mask  = mask >> 1;
            len   = 29 + mask[0];
            month += 1;
        end
        r.hijri_year  = g2h_pkg::YEAR_W'(idx + FIRST_YEAR);
        r.hijri_month = g2h_pkg::MONTH_W'(month);
        r.hijri_day   = g2h_pkg::MDAY_W'(rem + 1);
        r.year_day    = g2h_pkg::YDAY_W'(d - year_start[idx] + 1);
        return r;
    endfunction

    // Mostly in-table dates, weighted toward year and month boundaries and the table edges.
    function automatic logic [g2h_pkg::DAY_W-1:0] pick_day();
        int           sel;
        int           idx;
        int           k;
        int           m;
        int           off;
        int           day;
        int           last;
        logic [11:0]  mask;
        last = USED_ROWS - 1;
        sel  = $urandom_range(99);
        if (sel < 10)
        begin
            day = $urandom_range(DAY_MAX);
        end
        else if (sel < 20)
        begin
            idx = ($urandom_range(1) == 0) ? 0 : last;
            day = int'(year_start[idx]) + int'($urandom_range(6)) - 3;
        end
        else if (sel < 45)
        begin
            day = int'(year_start[$urandom_range(last)]) + int'($urandom_range(4)) - 2;
        end
        else if (sel < 60)
        begin
            idx  = $urandom_range(last - 1);
            mask = year_rows[4*idx];
            k    = $urandom_range(12, 1);
            off  = 0;
            for (m = 0; m < k; m++)
            begin
                off += 29 + mask[m];
            end
            day = int'(year_start[idx]) + off - int'($urandom_range(1));
        end
        else
        begin
            day = $urandom_range(year_start[last] - 1, year_start[0]);
        end
        return g2h_pkg::DAY_W'(day);
    endfunction

    task automatic offer_day(input logic [g2h_pkg::DAY_W-1:0] day, input logic typed,
                             input hijri_date_t want);
        if (idle_on && $urandom_range(3) == 0)
        begin
            gregorian.valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clk);
        end
        gregorian.valid      <= 1'b1;
        gregorian.day_number <= day;
        @(posedge clk);
        while (!gregorian.ready)
        begin
            @(posedge clk);
        end
        expected_dates.push_back(typed ? want : convert_day(day));
    endtask

    // Result side: random stall bursts, plus one long hold-off that backs the block up.
    initial
    begin
        hijri.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (choke_req)
            begin
                hijri.ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_req = 1'b0;
            end
            else if (idle_on && $urandom_range(15) == 0)
            begin
                hijri.ready <= 1'b0;
                repeat ($urandom_range(19, 1)) @(posedge clk);
            end
            hijri.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        hijri_date_t seen;
        hijri_date_t want;
        if (rst_n && hijri.valid && hijri.ready)
        begin
            seen.hijri_year   = hijri.hijri_year;
            seen.hijri_month  = hijri.hijri_month;
            seen.hijri_day    = hijri.hijri_day;
            seen.year_day     = hijri.year_day;
            seen.out_of_range = hijri.out_of_range;
            if (expected_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected result y=%0d m=%0d d=%0d yd=%0d oor=%0b", $realtime,
                             seen.hijri_year, seen.hijri_month, seen.hijri_day, seen.year_day,
                             seen.out_of_range);
                end
            end
            else
            begin
                want = expected_dates.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: expected y=%0d m=%0d d=%0d yd=%0d oor=%0b, got y=%0d m=%0d d=%0d yd=%0d oor=%0b",
                                 $realtime, want.hijri_year, want.hijri_month, want.hijri_day,
                                 want.year_day, want.out_of_range, seen.hijri_year,
                                 seen.hijri_month, seen.hijri_day, seen.year_day,
                                 seen.out_of_range);
                    end
                end
            end
        end
    end

    // Watchdog: any transaction on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((gregorian.valid && gregorian.ready) || (hijri.valid && hijri.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL gregorian_to_hijri_table");
            $finish;
        end
    end

    initial
    begin
        int  i;
        int  day;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        gregorian.valid      = 1'b0;
        gregorian.day_number = '0;
        for (i = 0; i < ROM_ROWS; i++)
        begin
            year_start[i] = gregorian_day(year_rows[4*i+1], year_rows[4*i+2], year_rows[4*i+3]);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_PROBES; i++)
        begin
            if (probes[i].anchor == NO_ANCHOR)
            begin
                day = probes[i].offset;
            end
            else
            begin
                day = int'(year_start[probes[i].anchor]) + probes[i].offset;
            end
            offer_day(g2h_pkg::DAY_W'(day), probes[i].typed, probes[i].want);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == CHOKE_AT)
            begin
                choke_req = 1'b1;
            end
            if (i == RANDOM_ITEMS - QUIET_TAIL)
            begin
                idle_on = 1'b0;
            end
            offer_day(pick_day(), 1'b0, NO_DATE);
        end
        gregorian.valid <= 1'b0;

        while (expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_dates.size() == 0)
        begin
            $display("PASS gregorian_to_hijri_table");
        end
        else
        begin
            $display("FAIL gregorian_to_hijri_table");
        end
        $finish;
    end

endmodule

### gregorian_to_hijri_table.f
rtl/core/g2h_pkg.sv
rtl/core/g2h_ifs.sv
rtl/core/g2h_ctrl.sv
rtl/core/g2h_datapath.sv
rtl/core/gregorian_to_hijri_table.sv
sim/gregorian_to_hijri_table_tb.sv
